// ===== hw/rtl/trkidw_pkg.sv =====
// ----------------------------------------------------------------------------
// trkidw_pkg
// Shared types and widths for the three-nearest contour ranker.
// ----------------------------------------------------------------------------
package trkidw_pkg;

  localparam int unsigned SLOTS  = 3;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned ELEV_W = 32;
  localparam int unsigned DIST_W = 32;
  localparam int unsigned TOL_W  = 16;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned NUM_W  = 98;
  localparam int unsigned DEN_W  = 66;
  localparam int unsigned REM_W  = 97;
  localparam int unsigned QUO_W  = 32;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned HELD_W = 2;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

  // one ranked line held by a cell
  typedef struct packed {
    logic              valid;
    logic [ELEV_W-1:0] elev;
    logic [DIST_W-1:0] dist_sq;
  } entry_t;

  // signals handed from each cell to its right neighbor
  typedef struct packed {
    logic              hit;
    logic [ELEV_W-1:0] key;
    logic              placed;
  } chain_t;

  // control and data broadcast to every cell
  typedef struct packed {
    logic              probe;
    logic              update;
    logic              clear;
    logic [ELEV_W-1:0] line_elev;
    logic [TOL_W-1:0]  tol;
    logic [ELEV_W-1:0] key_elev;
    logic [DIST_W-1:0] key_dist;
  } bcast_t;

endpackage

// ===== hw/rtl/trkidw_cell.sv =====
// ----------------------------------------------------------------------------
// trkidw_cell
// One rank slot: elevation match on probe, shift or load on update, empty on clear.
// ----------------------------------------------------------------------------
module trkidw_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  trkidw_pkg::bcast_t  bc_i,
  input  trkidw_pkg::chain_t  chain_i,
  output trkidw_pkg::chain_t  chain_o,
  input  trkidw_pkg::entry_t  left_i,
  output trkidw_pkg::entry_t  entry_o
);

  trkidw_pkg::entry_t entry_q, entry_d;
  logic               win_q, win_d;
  logic [trkidw_pkg::ELEV_W:0] diff;
  logic [trkidw_pkg::ELEV_W:0] gap;
  logic                        match;
  logic                        lt;

  assign diff  = {entry_q.elev[trkidw_pkg::ELEV_W-1], entry_q.elev}
               - {bc_i.line_elev[trkidw_pkg::ELEV_W-1], bc_i.line_elev};
  assign gap   = diff[trkidw_pkg::ELEV_W] ? (~diff + 33'd1) : diff;
  assign match = entry_q.valid
              && (gap < {{(trkidw_pkg::ELEV_W + 1 - trkidw_pkg::TOL_W){1'b0}}, bc_i.tol});
  assign lt    = !entry_q.valid || (bc_i.key_dist < entry_q.dist_sq);

  always_comb begin
    chain_o.hit    = chain_i.hit | match;
    chain_o.key    = (match && !chain_i.hit) ? entry_q.elev : chain_i.key;
    chain_o.placed = chain_i.placed | lt;
  end

  always_comb begin
    entry_d = entry_q;
    win_d   = win_q;
    if (bc_i.clear) begin
      entry_d = '0;
    end else if (bc_i.update && win_q) begin
      if (chain_i.placed) begin
        entry_d = left_i;
      end else if (lt) begin
        entry_d.valid   = 1'b1;
        entry_d.elev    = bc_i.key_elev;
        entry_d.dist_sq = bc_i.key_dist;
      end
    end
    // cells up to the first matching one take part in the update
    if (bc_i.probe) begin
      win_d = !chain_i.hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      win_q   <= 1'b0;
    end else begin
      entry_q <= entry_d;
      win_q   <= win_d;
    end
  end

  assign entry_o = entry_q;

endmodule

// ===== hw/rtl/trkidw_blend.sv =====
// ----------------------------------------------------------------------------
// trkidw_blend
// Inverse-distance weighting of the held lines: shared 32x32 multiplier,
// accumulators and a one-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
module trkidw_blend (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         go_i,
  input  trkidw_pkg::entry_t [trkidw_pkg::SLOTS-1:0]   ent_i,
  output logic                                         done_o,
  output logic [trkidw_pkg::ELEV_W-1:0]                result_o
);

  typedef enum logic [2:0] {
    B_IDLE,
    B_WMUL,
    B_MUL,
    B_ACC,
    B_ABS,
    B_DIV,
    B_SIGN,
    B_DONE
  } bstate_e;

  bstate_e                          st_q;
  logic [trkidw_pkg::IDX_W-1:0]     k_q;
  logic [trkidw_pkg::IDX_W-1:0]     nlast_q;
  logic                             half_q;
  logic [trkidw_pkg::CNT_W-1:0]     cnt_q;
  logic [trkidw_pkg::PROD_W-1:0]    w_q [trkidw_pkg::SLOTS];
  logic [trkidw_pkg::PROD_W-1:0]    prod_q;
  logic [trkidw_pkg::NUM_W-1:0]     num_q;
  logic [trkidw_pkg::DEN_W-1:0]     den_q;
  logic [trkidw_pkg::REM_W-1:0]     rem_q;
  logic [trkidw_pkg::REM_W-1:0]     dsh_q;
  logic [trkidw_pkg::QUO_W-1:0]     quo_q;
  logic                             neg_q;
  logic [trkidw_pkg::ELEV_W-1:0]    res_q;

  logic [trkidw_pkg::ELEV_W-1:0]    e_k;
  logic [trkidw_pkg::ELEV_W-1:0]    e_mag;
  logic [trkidw_pkg::PROD_W-1:0]    w_k;
  logic [trkidw_pkg::DIST_W-1:0]    mul_a;
  logic [trkidw_pkg::DIST_W-1:0]    mul_b;
  logic [trkidw_pkg::PROD_W-1:0]    product;
  logic [trkidw_pkg::NUM_W-1:0]     term;
  logic [trkidw_pkg::NUM_W-1:0]     num_next;
  logic [trkidw_pkg::NUM_W-1:0]     num_mag;
  logic                             rem_ge;
  logic [trkidw_pkg::SLOTS-1:0]     zero;

  assign e_k   = ent_i[k_q].elev;
  assign e_mag = e_k[trkidw_pkg::ELEV_W-1] ? (~e_k + 32'd1) : e_k;
  assign w_k   = w_q[k_q];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_q)
      B_WMUL: begin
        unique case (k_q)
          2'd0: begin
            mul_a = ent_i[1].dist_sq;
            mul_b = ent_i[2].dist_sq;
          end
          2'd1: begin
            mul_a = ent_i[0].dist_sq;
            mul_b = ent_i[2].dist_sq;
          end
          default: begin
            mul_a = ent_i[0].dist_sq;
            mul_b = ent_i[1].dist_sq;
          end
        endcase
      end
      B_MUL: begin
        mul_a = e_mag;
        mul_b = half_q ? w_k[63:32] : w_k[31:0];
      end
      default: ;
    endcase
  end

  assign product  = mul_a * mul_b;
  assign term     = half_q ? {2'b0, prod_q, 32'b0} : {34'b0, prod_q};
  assign num_next = e_k[trkidw_pkg::ELEV_W-1] ? (num_q - term) : (num_q + term);
  assign num_mag  = num_q[trkidw_pkg::NUM_W-1] ? (~num_q + 98'd1) : num_q;
  assign rem_ge   = (rem_q >= dsh_q);

  always_comb begin
    for (int i = 0; i < trkidw_pkg::SLOTS; i++) begin
      zero[i] = ent_i[i].valid && (ent_i[i].dist_sq == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= B_IDLE;
      k_q     <= '0;
      nlast_q <= '0;
      half_q  <= 1'b0;
      cnt_q   <= '0;
      for (int i = 0; i < trkidw_pkg::SLOTS; i++) begin
        w_q[i] <= '0;
      end
      prod_q  <= '0;
      num_q   <= '0;
      den_q   <= '0;
      rem_q   <= '0;
      dsh_q   <= '0;
      quo_q   <= '0;
      neg_q   <= 1'b0;
      res_q   <= '0;
    end else begin
      unique case (st_q)
        B_IDLE: begin
          if (go_i) begin
            num_q  <= '0;
            den_q  <= '0;
            k_q    <= '0;
            half_q <= 1'b0;
            // a zero distance or a single line gives the elevation itself
            if (zero[0]) begin
              res_q <= ent_i[0].elev;
              st_q  <= B_DONE;
            end else if (zero[1]) begin
              res_q <= ent_i[1].elev;
              st_q  <= B_DONE;
            end else if (zero[2]) begin
              res_q <= ent_i[2].elev;
              st_q  <= B_DONE;
            end else if (!ent_i[1].valid) begin
              res_q <= ent_i[0].elev;
              st_q  <= B_DONE;
            end else if (!ent_i[2].valid) begin
              w_q[0]  <= {32'b0, ent_i[1].dist_sq};
              w_q[1]  <= {32'b0, ent_i[0].dist_sq};
              nlast_q <= 2'd1;
              st_q    <= B_MUL;
            end else begin
              nlast_q <= 2'd2;
              st_q    <= B_WMUL;
            end
          end
        end
        B_WMUL: begin
          w_q[k_q] <= product;
          if (k_q == 2'd2) begin
            k_q  <= '0;
            st_q <= B_MUL;
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        B_MUL: begin
          prod_q <= product;
          st_q   <= B_ACC;
        end
        B_ACC: begin
          num_q <= num_next;
          if (!half_q) begin
            den_q  <= den_q + {2'b0, w_k};
            half_q <= 1'b1;
            st_q   <= B_MUL;
          end else begin
            half_q <= 1'b0;
            if (k_q == nlast_q) begin
              st_q <= B_ABS;
            end else begin
              k_q  <= k_q + 2'd1;
              st_q <= B_MUL;
            end
          end
        end
        B_ABS: begin
          neg_q <= num_q[trkidw_pkg::NUM_W-1];
          rem_q <= num_mag[trkidw_pkg::REM_W-1:0];
          dsh_q <= {den_q, {(trkidw_pkg::REM_W - trkidw_pkg::DEN_W){1'b0}}};
          quo_q <= '0;
          cnt_q <= 5'd31;
          st_q  <= B_DIV;
        end
        B_DIV: begin
          if (rem_ge) begin
            rem_q <= rem_q - dsh_q;
          end
          quo_q <= {quo_q[trkidw_pkg::QUO_W-2:0], rem_ge};
          dsh_q <= dsh_q >> 1;
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == '0) begin
            st_q <= B_SIGN;
          end
        end
        B_SIGN: begin
          res_q <= neg_q ? (~quo_q + 32'd1) : quo_q;
          st_q  <= B_DONE;
        end
        B_DONE: begin
          st_q <= B_IDLE;
        end
        default: begin
          st_q <= B_IDLE;
        end
      endcase
    end
  end

  assign done_o   = (st_q == B_DONE);
  assign result_o = res_q;

endmodule

// ===== hw/rtl/top3_contour_rank_idw.sv =====
// ----------------------------------------------------------------------------
// top3_contour_rank_idw
// Keeps the three nearest distinct contour lines of a pixel in a row of
// cells and gives their inverse-distance-weighted elevation on the last line.
// ----------------------------------------------------------------------------
//  channel  | handshake          | word
//  ---------+--------------------+------------------------------------------
//  line in  | start_i / busy_o   | line_elevation, distance_squared, last_line
//  result   | done_o (strobe)    | weighted_elevation, enough_lines, lines_held
//  config   | cfg_we_i           | match_tolerance
//
// a line is taken as a probe of all cells at accept, then the cell update
// a last line adds the blend: one line or a zero distance gives a held
// elevation directly, while two or three lines go through the shared
// 32x32 multiplier and the 32-step restoring divider
// reset empties every cell and sets match_tolerance to 1
// the result is shown for one cycle on done_o; the receiver cannot stall
module top3_contour_rank_idw (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic signed [trkidw_pkg::ELEV_W-1:0]   line_elevation_i,
  input  logic        [trkidw_pkg::DIST_W-1:0]   distance_squared_i,
  input  logic                                   last_line_i,
  input  logic                                   cfg_we_i,
  input  logic        [trkidw_pkg::TOL_W-1:0]    cfg_wdata_i,
  output logic                                   done_o,
  output logic signed [trkidw_pkg::ELEV_W-1:0]   weighted_elevation_o,
  output logic                                   enough_lines_o,
  output logic        [trkidw_pkg::HELD_W-1:0]   lines_held_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_LAUNCH,
    S_WAIT
  } state_e;

  state_e                               state_q;
  logic [trkidw_pkg::TOL_W-1:0]         tol_q;
  logic [trkidw_pkg::ELEV_W-1:0]        key_elev_q;
  logic [trkidw_pkg::DIST_W-1:0]        key_dist_q;
  logic                                 last_q;
  logic [trkidw_pkg::ELEV_W-1:0]        wel_q;
  logic                                 enough_q;
  logic [trkidw_pkg::HELD_W-1:0]        held_q;
  logic                                 done_q;

  trkidw_pkg::bcast_t                               bc;
  trkidw_pkg::chain_t                               chain [trkidw_pkg::SLOTS+1];
  trkidw_pkg::entry_t [trkidw_pkg::SLOTS-1:0]       ent;
  trkidw_pkg::entry_t                               lft [trkidw_pkg::SLOTS];
  logic                                             blend_done;
  logic [trkidw_pkg::ELEV_W-1:0]                    blend_res;
  logic [trkidw_pkg::HELD_W-1:0]                    held;
  logic                                             accept;

  assign accept = start_i && (state_q == S_IDLE);

  always_comb begin
    bc.probe     = accept;
    bc.update    = (state_q == S_UPDATE);
    bc.clear     = (state_q == S_WAIT) && blend_done;
    bc.line_elev = line_elevation_i;
    bc.tol       = tol_q;
    bc.key_elev  = key_elev_q;
    bc.key_dist  = key_dist_q;
  end

  always_comb begin
    chain[0].hit    = 1'b0;
    chain[0].key    = line_elevation_i;
    chain[0].placed = 1'b0;
  end

  for (genvar i = 0; i < trkidw_pkg::SLOTS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign lft[i] = '0;
    end else begin : g_link
      assign lft[i] = ent[i-1];
    end

    trkidw_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .bc_i    (bc),
      .chain_i (chain[i]),
      .chain_o (chain[i+1]),
      .left_i  (lft[i]),
      .entry_o (ent[i])
    );
  end

  trkidw_blend u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (state_q == S_LAUNCH),
    .ent_i    (ent),
    .done_o   (blend_done),
    .result_o (blend_res)
  );

  assign held = {1'b0, ent[0].valid} + {1'b0, ent[1].valid} + {1'b0, ent[2].valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      tol_q      <= trkidw_pkg::TOL_RESET;
      key_elev_q <= '0;
      key_dist_q <= '0;
      last_q     <= 1'b0;
      wel_q      <= '0;
      enough_q   <= 1'b0;
      held_q     <= '0;
      done_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            // matched line keeps its held elevation
            key_elev_q <= chain[trkidw_pkg::SLOTS].key;
            key_dist_q <= distance_squared_i;
            last_q     <= last_line_i;
            state_q    <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          state_q <= last_q ? S_LAUNCH : S_IDLE;
        end
        S_LAUNCH: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (blend_done) begin
            wel_q    <= blend_res;
            enough_q <= ent[0].valid && ent[1].valid;
            held_q   <= held;
            done_q   <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o               = (state_q != S_IDLE);
  assign done_o               = done_q;
  assign weighted_elevation_o = $signed(wel_q);
  assign enough_lines_o       = enough_q;
  assign lines_held_o         = held_q;

`ifndef SYNTHESIS
  a_fill_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!ent[1].valid || ent[0].valid) && (!ent[2].valid || ent[1].valid))
    else $error("rank cells not filled from the front");

  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!ent[1].valid || (ent[0].dist_sq <= ent[1].dist_sq))
    && (!ent[2].valid || (ent[1].dist_sq <= ent[2].dist_sq)))
    else $error("rank cells out of distance order");

  a_held_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (lines_held_o != '0) && !ent[0].valid)
    else $error("result with no line held or cells not cleared");

  a_enough: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enough_lines_o |-> lines_held_o[1])
    else $error("enough_lines set with fewer than two lines");

  a_blend_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blend_done |-> (state_q == S_WAIT))
    else $error("blend finished outside of wait");
`endif

endmodule
